FILE: rtl/rtcbm_pkg.sv
// Shared types and constants for the three-wire burst master.
package rtcbm_pkg;

   // Input kind codes as they arrive on the request word.
   localparam logic [1:0] KIND_TICK       = 2'd0;
   localparam logic [1:0] KIND_BURST_READ = 2'd1;
   localparam logic [1:0] KIND_BURST_WRITE = 2'd2;
   localparam logic [1:0] KIND_LOAD_BYTE  = 2'd3;

   // Command bytes sent to the clock chip.
   localparam logic [7:0] CMD_BURST_READ  = 8'hBF;
   localparam logic [7:0] CMD_BURST_WRITE = 8'hBE;
   localparam logic [7:0] CMD_PROTECT     = 8'h8E;
   localparam logic [7:0] PROTECT_ON      = 8'h80;
   localparam logic [7:0] PROTECT_OFF     = 8'h00;

   // Reset value of the gap register.
   localparam logic [15:0] GAP_TICKS_RESET = 16'd2000;

   // Classified operation handed from the front to the back.
   typedef enum logic [1:0] {
      OP_TICK,
      OP_READ,
      OP_WRITE,
      OP_LOAD
   } op_type;

   // Request word as seen on the input port.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] write_byte;
      logic [2:0] write_index;
      logic       data_in;
   } req_type;

   // Classified command held in the queue between front and back.
   typedef struct packed {
      op_type     op;
      logic [7:0] write_byte;
      logic [2:0] write_index;
      logic       data_in;
   } cmd_type;

   // Response word as seen on the result port.
   typedef struct packed {
      logic       chip_enable;
      logic       serial_clock;
      logic       data_out;
      logic       data_drive;
      logic [7:0] read_byte;
      logic [2:0] read_index;
      logic       read_valid;
      logic       busy_res;
      logic       done_res;
   } rsp_type;

endpackage

FILE: rtl/rtcbm_fifo.sv
// Small flip-flop queue with push/full and pop/empty handshakes.
module rtcbm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CntW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/rtcbm_front.sv
// Front end: accepts request words, classifies them and queues the commands.
module rtcbm_front
   import rtcbm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   input  logic    cmd_pop,
   output logic    cmd_empty,
   output cmd_type cmd_data
);

   cmd_type cmd_in;

   // Turn the raw kind code into an operation.
   always_comb begin
      cmd_in.write_byte  = req_data.write_byte;
      cmd_in.write_index = req_data.write_index;
      cmd_in.data_in     = req_data.data_in;
      unique case (req_data.kind)
         KIND_TICK:        cmd_in.op = OP_TICK;
         KIND_BURST_READ:  cmd_in.op = OP_READ;
         KIND_BURST_WRITE: cmd_in.op = OP_WRITE;
         KIND_LOAD_BYTE:   cmd_in.op = OP_LOAD;
         default:          cmd_in.op = OP_TICK;
      endcase
   end

   // Command queue toward the sequencer.
   rtcbm_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .push_data(cmd_in),
      .pop      (cmd_pop),
      .empty    (cmd_empty),
      .pop_data (cmd_data)
   );

endmodule

FILE: rtl/rtcbm_seq.sv
// Back end: pin sequencer, write buffer and gap register.
module rtcbm_seq
   import rtcbm_pkg::*;
#(
   parameter int BURST_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        cmd_empty,
   input  cmd_type     cmd_data,
   output logic        cmd_pop,
   input  logic        out_full,
   output logic        out_push,
   output rsp_type     out_data
);

   // Wide enough to count to BURST_BYTES and to index the eight-entry buffer.
   localparam int CntW = ($clog2(BURST_BYTES + 1) > 3) ? $clog2(BURST_BYTES + 1) : 3;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RD_PULSE,
      PH_WR_PULSE,
      PH_RD_CMD,
      PH_RD_DATA,
      PH_WR_UNLK,
      PH_WR_BURST,
      PH_WR_GAP,
      PH_WR_LOCK
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [2:0]      bit_count_ff, bit_count_in;
   logic [CntW-1:0] byte_count_ff, byte_count_in;
   logic [7:0]      shift_ff, shift_in;
   logic            clock_half_ff, clock_half_in;
   logic [15:0]     gap_count_ff, gap_count_in;
   logic [15:0]     gap_ticks_ff;
   logic            ce_ff, ce_in;
   logic            sck_ff, sck_in;
   logic            dout_ff, dout_in;
   logic            drive_ff, drive_in;
   logic [7:0]      wbuf_ff [8];
   logic            step;
   logic            byte_end;
   logic [7:0]      rbyte;
   logic [2:0]      ridx;
   logic            rvalid;
   logic            done;

   // One command is carried out per cycle when the result queue has room.
   assign step     = !cmd_empty && !out_full;
   assign cmd_pop  = step;
   assign out_push = step;
   assign byte_end = (bit_count_ff == 3'd7);

   // Next state of the sequencer and the pins.
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      byte_count_in = byte_count_ff;
      shift_in      = shift_ff;
      clock_half_in = clock_half_ff;
      gap_count_in  = gap_count_ff;
      ce_in         = ce_ff;
      sck_in        = sck_ff;
      dout_in       = dout_ff;
      drive_in      = drive_ff;
      rbyte         = '0;
      ridx          = '0;
      rvalid        = 1'b0;
      done          = 1'b0;
      if (step) begin
         unique case (cmd_data.op)
            OP_LOAD: begin
               // The buffer write happens in the storage block.
            end
            OP_READ, OP_WRITE: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in = (cmd_data.op == OP_READ) ? PH_RD_PULSE : PH_WR_PULSE;
                  ce_in    = 1'b1;
                  sck_in   = 1'b0;
                  dout_in  = 1'b0;
                  drive_in = 1'b1;
               end
            end
            OP_TICK: begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     // Pins hold what the last transaction left.
                  end
                  PH_RD_PULSE, PH_WR_PULSE: begin
                     ce_in         = 1'b0;
                     sck_in        = 1'b0;
                     dout_in       = 1'b0;
                     drive_in      = 1'b1;
                     byte_count_in = '0;
                     bit_count_in  = '0;
                     clock_half_in = 1'b0;
                     if (phase_ff == PH_RD_PULSE) begin
                        shift_in = CMD_BURST_READ;
                        phase_in = PH_RD_CMD;
                     end else begin
                        shift_in = CMD_PROTECT;
                        phase_in = PH_WR_UNLK;
                     end
                  end
                  PH_RD_CMD, PH_WR_UNLK, PH_WR_BURST, PH_WR_LOCK: begin
                     if (!clock_half_ff) begin
                        // Rising half: present the bit and raise the clock.
                        ce_in         = 1'b1;
                        drive_in      = 1'b1;
                        dout_in       = shift_ff[0];
                        sck_in        = 1'b1;
                        clock_half_in = 1'b1;
                     end else begin
                        sck_in        = 1'b0;
                        clock_half_in = 1'b0;
                        shift_in      = {1'b0, shift_ff[7:1]};
                        bit_count_in  = bit_count_ff + 1'b1;
                        if (byte_end) begin
                           bit_count_in = '0;
                           priority case (phase_ff)
                              PH_RD_CMD: begin
                                 phase_in      = PH_RD_DATA;
                                 drive_in      = 1'b0;
                                 dout_in       = 1'b0;
                                 byte_count_in = '0;
                                 shift_in      = '0;
                              end
                              PH_WR_UNLK: begin
                                 if (byte_count_ff == '0) begin
                                    byte_count_in = CntW'(1);
                                    shift_in      = PROTECT_OFF;
                                 end else begin
                                    ce_in         = 1'b0;
                                    phase_in      = PH_WR_BURST;
                                    byte_count_in = '0;
                                    shift_in      = CMD_BURST_WRITE;
                                 end
                              end
                              PH_WR_BURST: begin
                                 if (byte_count_ff < CntW'(BURST_BYTES - 1)) begin
                                    shift_in      = wbuf_ff[byte_count_ff[2:0]];
                                    byte_count_in = byte_count_ff + 1'b1;
                                 end else begin
                                    ce_in         = 1'b0;
                                    byte_count_in = '0;
                                    if (gap_ticks_ff == '0) begin
                                       phase_in = PH_WR_LOCK;
                                       shift_in = CMD_PROTECT;
                                    end else begin
                                       phase_in     = PH_WR_GAP;
                                       gap_count_in = gap_ticks_ff;
                                    end
                                 end
                              end
                              default: begin
                                 // Protect frame.
                                 if (byte_count_ff == '0) begin
                                    byte_count_in = CntW'(1);
                                    shift_in      = PROTECT_ON;
                                 end else begin
                                    ce_in         = 1'b0;
                                    phase_in      = PH_IDLE;
                                    byte_count_in = '0;
                                    done          = 1'b1;
                                 end
                              end
                           endcase
                        end
                     end
                  end
                  PH_WR_GAP: begin
                     gap_count_in = gap_count_ff - 1'b1;
                     if (gap_count_ff == 16'd1) begin
                        phase_in      = PH_WR_LOCK;
                        byte_count_in = '0;
                        shift_in      = CMD_PROTECT;
                        bit_count_in  = '0;
                        clock_half_in = 1'b0;
                     end
                  end
                  PH_RD_DATA: begin
                     if (!clock_half_ff) begin
                        // Sample on the rising half, LSB first.
                        sck_in        = 1'b1;
                        shift_in      = {cmd_data.data_in, shift_ff[7:1]};
                        clock_half_in = 1'b1;
                     end else begin
                        sck_in        = 1'b0;
                        clock_half_in = 1'b0;
                        bit_count_in  = bit_count_ff + 1'b1;
                        if (byte_end) begin
                           rvalid        = 1'b1;
                           rbyte         = shift_ff;
                           ridx          = byte_count_ff[2:0];
                           shift_in      = '0;
                           byte_count_in = byte_count_ff + 1'b1;
                           if (byte_count_ff >= CntW'(BURST_BYTES - 1)) begin
                              ce_in         = 1'b0;
                              phase_in      = PH_IDLE;
                              byte_count_in = '0;
                              done          = 1'b1;
                           end
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Result word shows the pins after this step.
   always_comb begin
      out_data.chip_enable  = ce_in;
      out_data.serial_clock = sck_in;
      out_data.data_out     = dout_in;
      out_data.data_drive   = drive_in;
      out_data.read_byte    = rbyte;
      out_data.read_index   = ridx;
      out_data.read_valid   = rvalid;
      out_data.busy_res     = (phase_in != PH_IDLE);
      out_data.done_res     = done;
   end

   // Sequencer state, pins and gap register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         byte_count_ff <= '0;
         shift_ff      <= '0;
         clock_half_ff <= 1'b0;
         gap_count_ff  <= '0;
         gap_ticks_ff  <= GAP_TICKS_RESET;
         ce_ff         <= 1'b0;
         sck_ff        <= 1'b0;
         dout_ff       <= 1'b0;
         drive_ff      <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         byte_count_ff <= byte_count_in;
         shift_ff      <= shift_in;
         clock_half_ff <= clock_half_in;
         gap_count_ff  <= gap_count_in;
         ce_ff         <= ce_in;
         sck_ff        <= sck_in;
         dout_ff       <= dout_in;
         drive_ff      <= drive_in;
         if (csr_write_enable) begin
            gap_ticks_ff <= csr_write_data;
         end
      end
   end

   // Write buffer, loaded by its own word kind.
   always_ff @(posedge clock) begin
      if (step && (cmd_data.op == OP_LOAD)) begin
         wbuf_ff[cmd_data.write_index] <= cmd_data.write_byte;
      end
   end

`ifndef SYNTHESIS
   // A finished transaction leaves the block idle.
   assert property (@(posedge clock) disable iff (reset)
      (step && out_data.done_res) |-> !out_data.busy_res)
      else $error("done reported while still busy");

   // A completed read byte comes with the clock low and the line released.
   assert property (@(posedge clock) disable iff (reset)
      (step && out_data.read_valid) |-> (!out_data.serial_clock && !out_data.data_drive))
      else $error("read byte completed with clock high or line driven");

   // Idle always sits at the low half of a bit.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> !clock_half_ff)
      else $error("idle with clock half set");

   // The gap counter never sits at zero inside the gap.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WR_GAP) |-> (gap_count_ff != '0))
      else $error("gap phase with zero count");
`endif

endmodule

FILE: rtl/rtc_three_wire_burst_master.sv
// Top level of the three-wire burst master for a serial clock chip.
//
//   Channel   Ports                                   Direction   Word
//   request   req_push, req_full, req_data            in          req_type
//   response  rsp_pop, rsp_empty, rsp_data            out         rsp_type
//   control   csr_write_enable, csr_write_data        in          gap ticks
//
// Each request word yields one response word; the sequencer handles one word per
// cycle while the response queue has room, so one word per cycle is sustained. A
// pushed word passes through the command queue and then the response queue before
// its response is visible. Reset is synchronous and clears both queues and the
// sequencer. A full response queue stalls the sequencer; the command queue then fills
// and raises req_full, while words already queued are kept.
module rtc_three_wire_burst_master
   import rtcbm_pkg::*;
#(
   parameter int BURST_BYTES = 8,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  req_type     req_data,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   cmd_type cmd_data;
   rsp_type seq_rsp;
   logic    cmd_empty;
   logic    cmd_pop;
   logic    out_full;
   logic    out_push;

   // Front end: classify and queue.
   rtcbm_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cmd_pop  (cmd_pop),
      .cmd_empty(cmd_empty),
      .cmd_data (cmd_data)
   );

   // Back end: drive the pins.
   rtcbm_seq #(
      .BURST_BYTES(BURST_BYTES)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .cmd_empty       (cmd_empty),
      .cmd_data        (cmd_data),
      .cmd_pop         (cmd_pop),
      .out_full        (out_full),
      .out_push        (out_push),
      .out_data        (seq_rsp)
   );

   // Response queue toward the consumer.
   rtcbm_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .full     (out_full),
      .push_data(seq_rsp),
      .pop      (rsp_pop),
      .empty    (rsp_empty),
      .pop_data (rsp_data)
   );

endmodule
